// ----- design/gds_pkg.sv -----
// Shared types, constants and calendar helpers for the Gregorian date stepper.
// Used by gds_sub, gds_core and the top level; no dependencies.
package gds_pkg;

    localparam int JUMP_BITS = 16;
    localparam int ALU_W     = (JUMP_BITS > 14) ? JUMP_BITS : 14;

    localparam logic [ALU_W-1:0] JUMP_MASK = ALU_W'((64'd1 << JUMP_BITS) - 64'd1);

    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [6:0]  CENT_RESET  = 7'd20;
    localparam logic [6:0]  YY_RESET    = 7'd0;
    localparam logic [6:0]  TWO_DIG_MAX = 7'd99;
    localparam logic [3:0]  MONTH_JAN   = 4'd1;
    localparam logic [3:0]  MONTH_MAR   = 4'd3;
    localparam logic [3:0]  MONTH_DEC   = 4'd12;
    localparam logic [4:0]  DAY_FIRST   = 5'd1;

    localparam logic [ALU_W-1:0] CENTURY   = ALU_W'(100);
    localparam logic [ALU_W-1:0] MOD_BIG   = ALU_W'(112);
    localparam logic [ALU_W-1:0] MOD_SEVEN = ALU_W'(7);

    typedef enum logic [2:0] {
        OP_PRE_INC   = 3'd0,
        OP_POST_INC  = 3'd1,
        OP_PRE_DEC   = 3'd2,
        OP_POST_DEC  = 3'd3,
        OP_JUMP_FWD  = 3'd4,
        OP_JUMP_BACK = 3'd5,
        OP_LOAD      = 3'd6,
        OP_NOP       = 3'd7
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_SPLIT,
        ST_LCHECK,
        ST_REPORT,
        ST_ZSUM,
        ST_ZMOD,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic        leap;
        logic        range_error;
    } result_t;

    // Year is held as century and two-digit year; 100 is a multiple of 4.
    function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] yy);
        return (yy[1:0] == 2'd0) && ((yy != 7'd0) || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // 13*(m+1)/5 with January and February counted as months 13 and 14.
    function automatic logic [5:0] zeller_month_term(input logic [3:0] month);
        logic [5:0] t;
        case (month)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// ----- design/gds_sub.sv -----
// Shared subtract-and-compare unit of the date stepper.
// Depends on gds_pkg for the operand width.
module gds_sub (
    input  logic [gds_pkg::ALU_W-1:0] a,
    input  logic [gds_pkg::ALU_W-1:0] b,
    output logic [gds_pkg::ALU_W-1:0] diff,
    output logic                      borrow
);
    import gds_pkg::*;

    // borrow set means a < b
    assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ----- design/gds_core.sv -----
// Sequencer and datapath of the date stepper: walks dates month by month,
// splits loaded years, and reduces Zeller's sum, all through one gds_sub.
// Depends on gds_pkg and gds_sub.
module gds_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gds_pkg::op_t        in_op,
    input  logic [15:0]         in_jump,
    input  logic [13:0]         in_year,
    input  logic [3:0]          in_month,
    input  logic [4:0]          in_day,
    output logic                res_valid,
    input  logic                res_ready,
    output gds_pkg::result_t    res
);
    import gds_pkg::*;

    state_t state_reg, state_next;

    logic             post_reg, post_next;
    logic             err_reg, err_next;
    logic             big_reg, big_next;
    logic [ALU_W-1:0] rem_reg, rem_next;
    logic [2:0]       h_reg, h_next;

    // working date
    logic [6:0] wc_reg, wc_next, wy_reg, wy_next;
    logic [3:0] wm_reg, wm_next;
    logic [4:0] wd_reg, wd_next;
    // stored date
    logic [6:0] dc_reg, dc_next, dy_reg, dy_next;
    logic [3:0] dm_reg, dm_next;
    logic [4:0] dd_reg, dd_next;
    // reported date
    logic [6:0] rc_reg, rc_next, ry_reg, ry_next;
    logic [3:0] rm_reg, rm_next;
    logic [4:0] rd_reg, rd_next;
    // load fields
    logic [3:0] lm_reg, lm_next;
    logic [4:0] ld_reg, ld_next;

    logic [ALU_W-1:0] sub_a, sub_b, sub_diff;
    logic             sub_borrow;

    logic             accept;
    logic             load_bad;
    logic [4:0]       dim_cur;
    logic [5:0]       fwd_span;
    logic             month_wrap;
    logic [3:0]       pm;
    logic [6:0]       pc, py;
    logic             below_first;
    logic [4:0]       dim_prev;
    logic             lday_bad;
    logic             zwrap;
    logic [6:0]       zc, zy;
    logic [9:0]       zsum;
    logic [3:0]       wd_plus;

    gds_sub u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_bad = (in_year == 14'd0) || (in_year > YEAR_MAX) || (in_month == 4'd0)
                   || (in_month > MONTH_DEC) || (in_day == 5'd0);

    // forward: days left in this month plus one
    assign dim_cur  = days_in(wm_reg, is_leap(wc_reg, wy_reg));
    assign fwd_span = {1'b0, dim_cur} - {1'b0, wd_reg} + 6'd1;

    // backward: previous month and its year
    assign month_wrap  = (wm_reg == MONTH_JAN);
    assign pm          = month_wrap ? MONTH_DEC : wm_reg - 4'd1;
    assign py          = !month_wrap ? wy_reg : ((wy_reg == 7'd0) ? TWO_DIG_MAX : wy_reg - 7'd1);
    assign pc          = (month_wrap && (wy_reg == 7'd0)) ? wc_reg - 7'd1 : wc_reg;
    assign below_first = month_wrap && (wc_reg == 7'd0) && (wy_reg == 7'd1);
    assign dim_prev    = days_in(pm, is_leap(pc, py));

    assign lday_bad = (ld_reg > days_in(lm_reg, is_leap(wc_reg, wy_reg)));

    // Zeller: January and February belong to the previous year
    assign zwrap = (rm_reg < MONTH_MAR);
    assign zy    = !zwrap ? ry_reg : ((ry_reg == 7'd0) ? TWO_DIG_MAX : ry_reg - 7'd1);
    assign zc    = (zwrap && (ry_reg == 7'd0)) ? rc_reg - 7'd1 : rc_reg;
    assign zsum  = 10'(rd_reg) + 10'(zeller_month_term(rm_reg)) + 10'(zy) + 10'(zy[6:2])
                 + 10'(zc[6:2]) + {1'b0, zc, 2'b00} + 10'(zc);

    assign wd_plus = 4'(h_reg) + 4'd5;

    // shared unit operand select
    always_comb
    begin
        sub_a = rem_reg;
        unique case (state_reg)
            ST_FWD:   sub_b = ALU_W'(fwd_span);
            ST_BWD:   sub_b = ALU_W'(wd_reg);
            ST_SPLIT: sub_b = CENTURY;
            ST_ZMOD:  sub_b = big_reg ? MOD_BIG : MOD_SEVEN;
            default:  sub_b = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_op)
                        OP_PRE_INC, OP_POST_INC, OP_JUMP_FWD:  state_next = ST_FWD;
                        OP_PRE_DEC, OP_POST_DEC, OP_JUMP_BACK: state_next = ST_BWD;
                        OP_LOAD:  state_next = load_bad ? ST_REPORT : ST_SPLIT;
                        OP_NOP:   state_next = ST_REPORT;
                    endcase
                end
            end
            ST_FWD:
            begin
                if (sub_borrow || ((wm_reg == MONTH_DEC) && (wy_reg == TWO_DIG_MAX)
                                   && (wc_reg == TWO_DIG_MAX)))
                    state_next = ST_REPORT;
            end
            ST_BWD:
            begin
                if (sub_borrow || below_first)
                    state_next = ST_REPORT;
            end
            ST_SPLIT:
            begin
                if (sub_borrow)
                    state_next = ST_LCHECK;
            end
            ST_LCHECK: state_next = ST_REPORT;
            ST_REPORT: state_next = ST_ZSUM;
            ST_ZSUM:   state_next = ST_ZMOD;
            ST_ZMOD:
            begin
                if (sub_borrow && !big_reg)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        post_next = post_reg;
        err_next  = err_reg;
        big_next  = big_reg;
        rem_next  = rem_reg;
        h_next    = h_reg;
        wc_next   = wc_reg;
        wy_next   = wy_reg;
        wm_next   = wm_reg;
        wd_next   = wd_reg;
        dc_next   = dc_reg;
        dy_next   = dy_reg;
        dm_next   = dm_reg;
        dd_next   = dd_reg;
        rc_next   = rc_reg;
        ry_next   = ry_reg;
        rm_next   = rm_reg;
        rd_next   = rd_reg;
        lm_next   = lm_reg;
        ld_next   = ld_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wc_next   = dc_reg;
                    wy_next   = dy_reg;
                    wm_next   = dm_reg;
                    wd_next   = dd_reg;
                    lm_next   = in_month;
                    ld_next   = in_day;
                    post_next = (in_op == OP_POST_INC) || (in_op == OP_POST_DEC);
                    err_next  = (in_op == OP_LOAD) && load_bad;
                    unique case (in_op)
                        OP_JUMP_FWD, OP_JUMP_BACK: rem_next = ALU_W'(in_jump) & JUMP_MASK;
                        OP_LOAD:
                        begin
                            rem_next = ALU_W'(in_year);
                            wc_next  = 7'd0;
                        end
                        default: rem_next = ALU_W'(1);
                    endcase
                end
            end
            ST_FWD:
            begin
                if (sub_borrow)
                    wd_next = wd_reg + rem_reg[4:0];
                else
                begin
                    rem_next = sub_diff;
                    wd_next  = DAY_FIRST;
                    if (wm_reg == MONTH_DEC)
                    begin
                        wm_next = MONTH_JAN;
                        if (wy_reg == TWO_DIG_MAX)
                        begin
                            if (wc_reg == TWO_DIG_MAX)
                                err_next = 1'b1;
                            wy_next = 7'd0;
                            wc_next = wc_reg + 7'd1;
                        end
                        else
                            wy_next = wy_reg + 7'd1;
                    end
                    else
                        wm_next = wm_reg + 4'd1;
                end
            end
            ST_BWD:
            begin
                if (sub_borrow)
                    wd_next = wd_reg - rem_reg[4:0];
                else
                begin
                    rem_next = sub_diff;
                    err_next = below_first;
                    wm_next  = pm;
                    wy_next  = py;
                    wc_next  = pc;
                    wd_next  = dim_prev;
                end
            end
            ST_SPLIT:
            begin
                if (sub_borrow)
                    wy_next = rem_reg[6:0];
                else
                begin
                    rem_next = sub_diff;
                    wc_next  = wc_reg + 7'd1;
                end
            end
            ST_LCHECK:
            begin
                if (lday_bad)
                    err_next = 1'b1;
                else
                begin
                    wm_next = lm_reg;
                    wd_next = ld_reg;
                end
            end
            ST_REPORT:
            begin
                // capture the reported date, then commit unless refused
                if (post_reg || err_reg)
                begin
                    rc_next = dc_reg;
                    ry_next = dy_reg;
                    rm_next = dm_reg;
                    rd_next = dd_reg;
                end
                else
                begin
                    rc_next = wc_reg;
                    ry_next = wy_reg;
                    rm_next = wm_reg;
                    rd_next = wd_reg;
                end
                if (!err_reg)
                begin
                    dc_next = wc_reg;
                    dy_next = wy_reg;
                    dm_next = wm_reg;
                    dd_next = wd_reg;
                end
            end
            ST_ZSUM:
            begin
                rem_next = ALU_W'(zsum);
                big_next = 1'b1;
            end
            ST_ZMOD:
            begin
                if (sub_borrow)
                begin
                    big_next = 1'b0;
                    if (!big_reg)
                        h_next = rem_reg[2:0];
                end
                else
                    rem_next = sub_diff;
            end
            ST_RESULT: ;
            default: ;
        endcase
    end

    always_comb
    begin
        res_valid       = (state_reg == ST_RESULT);
        res.year        = 14'(rc_reg) * 14'd100 + 14'(ry_reg);
        res.month       = rm_reg;
        res.day         = rd_reg;
        res.weekday     = (wd_plus >= 4'd7) ? 3'(wd_plus - 4'd7) : wd_plus[2:0];
        res.leap        = is_leap(rc_reg, ry_reg);
        res.range_error = err_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dc_reg    <= CENT_RESET;
            dy_reg    <= YY_RESET;
            dm_reg    <= MONTH_JAN;
            dd_reg    <= DAY_FIRST;
        end
        else
        begin
            state_reg <= state_next;
            dc_reg    <= dc_next;
            dy_reg    <= dy_next;
            dm_reg    <= dm_next;
            dd_reg    <= dd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        post_reg <= post_next;
        err_reg  <= err_next;
        big_reg  <= big_next;
        rem_reg  <= rem_next;
        h_reg    <= h_next;
        wc_reg   <= wc_next;
        wy_reg   <= wy_next;
        wm_reg   <= wm_next;
        wd_reg   <= wd_next;
        rc_reg   <= rc_next;
        ry_reg   <= ry_next;
        rm_reg   <= rm_next;
        rd_reg   <= rd_next;
        lm_reg   <= lm_next;
        ld_reg   <= ld_next;
    end

endmodule

// ----- design/gregorian_date_stepper.sv -----
// Steps: an accepted operation walks the date month by month, forward or backward, or
// for a load splits the year into century and two-digit year by repeated subtraction
// of 100 and checks the day; it then reports the date and reduces Zeller's sum, first
// by repeated subtraction of 112 and then of 7, before the result is offered.
// Throughput: one transaction at a time, set by the shared subtractor in gds_core.
// Reset: date 2000-01-01, no result pending; one finished result may wait in the
// output register while the next transaction is taken.
module gregorian_date_stepper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // jump_days, load_year, load_month, load_day, pad
    input  logic [2:0]  s_axis_tuser,   // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_year, out_month, out_day, weekday, leap_year, pad
    output logic        m_axis_tuser    // range_error
);
    import gds_pkg::*;

    logic    res_valid, res_ready;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    gds_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (op_t'(s_axis_tuser)),
        .in_jump   (s_axis_tdata[15:0]),
        .in_year   (s_axis_tdata[29:16]),
        .in_month  (s_axis_tdata[33:30]),
        .in_day    (s_axis_tdata[38:34]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // take a result when the output register is empty or draining
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
                out_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.leap, out_reg.weekday, out_reg.day,
                            out_reg.month, out_reg.year};
    assign m_axis_tuser  = out_reg.range_error;

endmodule

// ----- design/gds_checker.sv -----
// Port-level checks for the date stepper, bound to the top level.
// Depends on the top level's port list only.
module gds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // one transaction in flight: ready drops after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a transaction is in flight");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[17:14] != 4'd0) && (m_axis_tdata[17:14] <= 4'd12)
            && (m_axis_tdata[22:18] != 5'd0) && (m_axis_tdata[25:23] != 3'd7)
            && (m_axis_tdata[13:0] != 14'd0) && (m_axis_tdata[13:0] <= 14'd9999))
        else $error("result date out of range");

    a_leap_year: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[26] |-> (m_axis_tdata[1:0] == 2'd0))
        else $error("leap flag on a year not divisible by four");

endmodule

bind gregorian_date_stepper gds_checker u_checker (.*);
